[rtl/core/keyed_price_table_max_min_defines.svh]
// ---------------------------------------------------------------------------
// keyed price table assertion macros
// shared property wrappers for the keyed price table rtl
// ---------------------------------------------------------------------------
`ifndef KEYED_PRICE_TABLE_MAX_MIN_DEFINES_SVH
`define KEYED_PRICE_TABLE_MAX_MIN_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KPTMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kptmm same-cycle check failed");

// next-cycle implication, disabled during reset
`define KPTMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kptmm next-cycle check failed");

`endif

[rtl/core/kptmm_pkg.sv]
// ---------------------------------------------------------------------------
// kptmm_pkg
// table size, index widths and field widths of the keyed price table
// ---------------------------------------------------------------------------
`default_nettype none

package kptmm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STAMP_W     = 32;
    localparam int PRICE_W     = 30;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [PRICE_W-1:0] price_t;

endpackage

`default_nettype wire

[rtl/core/kptmm_upd_if.sv]
// ---------------------------------------------------------------------------
// kptmm_upd_if
// update channel: one stamp and price word per handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface kptmm_upd_if;
    logic              valid;
    logic              ready;
    kptmm_pkg::stamp_t stamp_in;
    kptmm_pkg::price_t price_in;

    modport source (output valid, output stamp_in, output price_in, input ready);
    modport sink   (input valid, input stamp_in, input price_in, output ready);
endinterface

`default_nettype wire

[rtl/core/kptmm_res_if.sv]
// ---------------------------------------------------------------------------
// kptmm_res_if
// result channel: latest, max and min price plus drop flag per word
// ---------------------------------------------------------------------------
`default_nettype none

interface kptmm_res_if;
    logic              valid;
    logic              ready;
    kptmm_pkg::price_t latest_price;
    kptmm_pkg::price_t max_price;
    kptmm_pkg::price_t min_price;
    logic              dropped;

    modport source (output valid, output latest_price, output max_price,
                    output min_price, output dropped, input ready);
    modport sink   (input valid, input latest_price, input max_price,
                    input min_price, input dropped, output ready);
endinterface

`default_nettype wire

[rtl/core/kptmm_slot_ram.sv]
// ---------------------------------------------------------------------------
// kptmm_slot_ram
// stamp and price storage, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module kptmm_slot_ram (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire kptmm_pkg::addr_t  waddr,
    input  wire kptmm_pkg::stamp_t wstamp,
    input  wire kptmm_pkg::price_t wprice,
    input  wire kptmm_pkg::addr_t  raddr,
    output      kptmm_pkg::stamp_t rstamp,
    output      kptmm_pkg::price_t rprice
);

    kptmm_pkg::stamp_t stamp_mem [kptmm_pkg::TABLE_DEPTH];
    kptmm_pkg::price_t price_mem [kptmm_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stamp_mem[waddr] <= wstamp;
            price_mem[waddr] <= wprice;
        end
        rstamp <= stamp_mem[raddr];
        rprice <= price_mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/keyed_price_table_max_min.sv]
// flow: an accepted update word is captured, then a scan reads every slot in turn over the
//   one read port of the slot memory, then the final step writes the table and the result
//   word; a new update word is taken only in the idle state after that, and a result word
//   waiting downstream stalls only the final step
// reset: asynchronous, active low; clears all slot valid bits at once, so the table is
//   empty right after reset with no clearing pass
// ---------------------------------------------------------------------------
// keyed_price_table_max_min
// keyed price table that tracks the latest, greatest and least stored price
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyed_price_table_max_min_defines.svh"

module keyed_price_table_max_min (
    input wire logic       clk,
    input wire logic       rst_n,
    kptmm_upd_if.sink      upd,
    kptmm_res_if.source    res
);

    localparam int DEPTH = kptmm_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    // sequencer state
    state_t            state_reg, state_next;
    kptmm_pkg::cnt_t   addr_reg, addr_next;
    logic              proc_en_reg, proc_en_next;
    logic              proc_vld_reg, proc_vld_next;
    kptmm_pkg::addr_t  proc_idx_reg, proc_idx_next;

    // captured update word
    kptmm_pkg::stamp_t stamp_reg, stamp_next;
    kptmm_pkg::price_t price_reg, price_next;

    // match and free slot search
    logic              hit_reg, hit_next;
    kptmm_pkg::addr_t  hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    kptmm_pkg::addr_t  free_idx_reg, free_idx_next;

    // running latest / max / min
    logic              any_reg, any_next;
    kptmm_pkg::stamp_t best_reg, best_next;
    kptmm_pkg::price_t latest_reg, latest_next;
    kptmm_pkg::price_t hi_reg, hi_next;
    kptmm_pkg::price_t lo_reg, lo_next;

    // slot valid bits, one flop per slot
    logic [DEPTH-1:0]  valid_reg, valid_next;

    // result word register
    logic              res_valid_reg, res_valid_next;
    kptmm_pkg::price_t res_latest_reg, res_latest_next;
    kptmm_pkg::price_t res_hi_reg, res_hi_next;
    kptmm_pkg::price_t res_lo_reg, res_lo_next;
    logic              res_drop_reg, res_drop_next;

    // memory ports
    logic              ram_we;
    kptmm_pkg::addr_t  ram_waddr;
    kptmm_pkg::addr_t  ram_raddr;
    kptmm_pkg::stamp_t rd_stamp;
    kptmm_pkg::price_t rd_price;

    // shared compare unit inputs
    logic              cand_en;
    kptmm_pkg::stamp_t cand_stamp;
    kptmm_pkg::price_t cand_price;

    logic              is_hit;
    logic              out_free;
    logic              scan_issue;

    kptmm_slot_ram u_slot_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wstamp (stamp_reg),
        .wprice (price_reg),
        .raddr  (ram_raddr),
        .rstamp (rd_stamp),
        .rprice (rd_price)
    );

    assign upd.ready        = (state_reg == S_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.latest_price = res_latest_reg;
    assign res.max_price    = res_hi_reg;
    assign res.min_price    = res_lo_reg;
    assign res.dropped      = res_drop_reg;

    assign out_free   = !res_valid_reg || res.ready;
    assign scan_issue = (state_reg == S_SCAN) && (addr_reg < kptmm_pkg::cnt_t'(DEPTH));
    assign ram_raddr  = addr_reg[kptmm_pkg::ADDR_W-1:0];
    assign is_hit     = (rd_stamp == stamp_reg);
    assign ram_we     = (state_reg == S_DONE) && out_free && (hit_reg || free_reg);
    assign ram_waddr  = hit_reg ? hit_idx_reg : free_idx_reg;

    // candidate entry fed to the compare unit: a stored slot during the scan
    // (with a matching stamp taking the new price), the inserted pair at the end
    always_comb
    begin
        cand_en    = 1'b0;
        cand_stamp = stamp_reg;
        cand_price = price_reg;
        if (state_reg == S_SCAN)
        begin
            cand_en    = proc_en_reg && proc_vld_reg;
            cand_stamp = rd_stamp;
            cand_price = is_hit ? price_reg : rd_price;
        end
        else if (state_reg == S_DONE)
        begin
            cand_en = !hit_reg && free_reg;
        end
    end

    // shared compare unit: folds one entry into latest / max / min
    always_comb
    begin
        any_next    = any_reg;
        best_next   = best_reg;
        latest_next = latest_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        if (cand_en)
        begin
            any_next = 1'b1;
            if (!any_reg)
            begin
                best_next   = cand_stamp;
                latest_next = cand_price;
                hi_next     = cand_price;
                lo_next     = cand_price;
            end
            else
            begin
                if (cand_stamp > best_reg)
                begin
                    best_next   = cand_stamp;
                    latest_next = cand_price;
                end
                if (cand_price > hi_reg)
                begin
                    hi_next = cand_price;
                end
                if (cand_price < lo_reg)
                begin
                    lo_next = cand_price;
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        proc_en_next    = 1'b0;
        proc_vld_next   = proc_vld_reg;
        proc_idx_next   = proc_idx_reg;
        stamp_next      = stamp_reg;
        price_next      = price_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_latest_next = res_latest_reg;
        res_hi_next     = res_hi_reg;
        res_lo_next     = res_lo_reg;
        res_drop_next   = res_drop_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (upd.valid)
                begin
                    stamp_next = upd.stamp_in;
                    price_next = upd.price_in;
                    addr_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle; the read data comes back from the registered read port
                if (scan_issue)
                begin
                    proc_en_next  = 1'b1;
                    proc_idx_next = ram_raddr;
                    proc_vld_next = valid_reg[ram_raddr];
                    addr_next     = addr_reg + kptmm_pkg::cnt_t'(1);
                end
                if (proc_en_reg)
                begin
                    if (proc_vld_reg)
                    begin
                        if (is_hit && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = proc_idx_reg;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = proc_idx_reg;
                    end
                end
                if (!scan_issue && !proc_en_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (!hit_reg && free_reg)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    res_valid_next  = 1'b1;
                    res_latest_next = latest_next;
                    res_hi_next     = hi_next;
                    res_lo_next     = lo_next;
                    res_drop_next   = !hit_reg && !free_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            proc_en_reg    <= 1'b0;
            proc_vld_reg   <= 1'b0;
            proc_idx_reg   <= '0;
            stamp_reg      <= '0;
            price_reg      <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            any_reg        <= 1'b0;
            best_reg       <= '0;
            latest_reg     <= '0;
            hi_reg         <= '0;
            lo_reg         <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_latest_reg <= '0;
            res_hi_reg     <= '0;
            res_lo_reg     <= '0;
            res_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            proc_en_reg    <= proc_en_next;
            proc_vld_reg   <= proc_vld_next;
            proc_idx_reg   <= proc_idx_next;
            stamp_reg      <= stamp_next;
            price_reg      <= price_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            free_reg       <= free_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
            res_latest_reg <= res_latest_next;
            res_hi_reg     <= res_hi_next;
            res_lo_reg     <= res_lo_next;
            res_drop_reg   <= res_drop_next;
            // fresh fold for every update word
            if (state_reg == S_IDLE)
            begin
                any_reg    <= 1'b0;
                best_reg   <= '0;
                latest_reg <= '0;
                hi_reg     <= '0;
                lo_reg     <= '0;
            end
            else
            begin
                any_reg    <= any_next;
                best_reg   <= best_next;
                latest_reg <= latest_next;
                hi_reg     <= hi_next;
                lo_reg     <= lo_next;
            end
        end
    end

    // table is written only in the final step
    `KPTMM_ASSERT_IMP(a_we_done, clk, rst_n, ram_we, state_reg == S_DONE)
    // valid bits change only in the final step
    `KPTMM_ASSERT_NXT(a_valid_hold, clk, rst_n, state_reg != S_DONE,
                      valid_reg == $past(valid_reg))
    // a dropped word means every slot was taken
    `KPTMM_ASSERT_IMP(a_drop_full, clk, rst_n, res_valid_reg && res_drop_reg, &valid_reg)
    // a matched slot is always a stored one
    `KPTMM_ASSERT_IMP(a_hit_valid, clk, rst_n, hit_reg, valid_reg[hit_idx_reg])
    // an accepted word starts the scan
    `KPTMM_ASSERT_NXT(a_accept_scan, clk, rst_n, upd.valid && upd.ready,
                      state_reg == S_SCAN)

endmodule

`default_nettype wire

[sim/kptmm_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kptmm_checker
// watches the update and result channels of the keyed price table, keeps a
// shadow copy of the slots and compares every result word with the quote
// that the shadow table gives for the matching update word
// ---------------------------------------------------------------------------

module kptmm_checker
    import kptmm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    kptmm_upd_if  upd,
    kptmm_res_if  res,
    output int    fail_count,
    output int    pending_count
);

    typedef struct packed {
        price_t latest_price;
        price_t max_price;
        price_t min_price;
        logic   dropped;
    } quote_t;

    logic   shadow_used [TABLE_DEPTH];
    stamp_t shadow_key  [TABLE_DEPTH];
    price_t shadow_val  [TABLE_DEPTH];
    quote_t quotes_due [$];
    int     fails;

    // apply one update to the shadow table and return the quote after it
    function automatic quote_t book_update(input stamp_t stamp, input price_t price);
        int     hit_idx;
        int     free_idx;
        logic   seen;
        stamp_t top_key;
        quote_t q;
        hit_idx  = -1;
        free_idx = -1;
        seen     = 1'b0;
        top_key  = '0;
        q        = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (shadow_used[i])
            begin
                if (hit_idx < 0 && shadow_key[i] == stamp)
                    hit_idx = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (hit_idx >= 0)
            shadow_val[hit_idx] = price;
        else if (free_idx >= 0)
        begin
            shadow_used[free_idx] = 1'b1;
            shadow_key[free_idx]  = stamp;
            shadow_val[free_idx]  = price;
        end
        else
            q.dropped = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (shadow_used[i])
            begin
                if (!seen)
                begin
                    seen           = 1'b1;
                    top_key        = shadow_key[i];
                    q.latest_price = shadow_val[i];
                    q.max_price    = shadow_val[i];
                    q.min_price    = shadow_val[i];
                end
                else
                begin
                    if (shadow_key[i] > top_key)
                    begin
                        top_key        = shadow_key[i];
                        q.latest_price = shadow_val[i];
                    end
                    if (shadow_val[i] > q.max_price)
                        q.max_price = shadow_val[i];
                    if (shadow_val[i] < q.min_price)
                        q.min_price = shadow_val[i];
                end
            end
        end
        return q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        quote_t want;
        quote_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                shadow_used[i] = 1'b0;
            quotes_due.delete();
            fails         = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (upd.valid && upd.ready)
                quotes_due.push_back(book_update(upd.stamp_in, upd.price_in));
            if (res.valid && res.ready)
            begin
                got.latest_price = res.latest_price;
                got.max_price    = res.max_price;
                got.min_price    = res.min_price;
                got.dropped      = res.dropped;
                if (quotes_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result word with none expected, actual %0d %0d %0d %0d",
                             $time, got.latest_price, got.max_price, got.min_price,
                             got.dropped);
                end
                else
                begin
                    want = quotes_due.pop_front();
                    if (want != got)
                    begin
                        fails++;
                        $display("%0t: mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                                 $time, want.latest_price, want.max_price,
                                 want.min_price, want.dropped, got.latest_price,
                                 got.max_price, got.min_price, got.dropped);
                    end
                end
            end
            fail_count    <= fails;
            pending_count <= quotes_due.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives price updates into the keyed price table with random gaps and
// result-side stalls, lets the checker predict and compare, gives the verdict
// ---------------------------------------------------------------------------

module testbench;
    import kptmm_pkg::*;

    // timing of the run
    localparam int IDLE_MAX        = 16;
    localparam int RANDOM_ITEMS    = 535;
    localparam int HOLD_OFF_AT     = 150;   // result word after which the sink stalls
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = TABLE_DEPTH + 3 + 2 * IDLE_MAX;

    logic clk;
    logic rst_n;

    kptmm_upd_if upd ();
    kptmm_res_if res ();

    int     fail_count;
    int     pending_count;
    int     idle_count  = 0;
    int     words_sent  = 0;
    int     words_taken = 0;
    stamp_t stored_keys [$];   // stamps the table should hold, in slot order

    keyed_price_table_max_min u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .res   (res)
    );

    kptmm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .upd           (upd),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // a stretch of back-to-back words every 64, random gaps otherwise
    function automatic int idle_draw(input int seq);
        if ((seq % 64) < 12)
            return 0;
        return $urandom_range(IDLE_MAX, 0);
    endfunction

    // prices lean on the extremes and on tiny values so max and min ties occur
    function automatic price_t pick_price();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2:       return price_t'($urandom_range(15, 0));
            3:       return '1 - price_t'($urandom_range(15, 0));
            default: return price_t'($urandom);
        endcase
    endfunction

    // new stamps: near zero, near the top of the unsigned range, or anywhere
    function automatic stamp_t pick_stamp();
        case ($urandom_range(7, 0))
            0:       return stamp_t'($urandom_range(63, 0));
            1:       return '1 - stamp_t'($urandom_range(63, 0));
            2:       return {1'b0, 31'($urandom)};
            default: return stamp_t'($urandom);
        endcase
    endfunction

    function automatic logic is_stored(input stamp_t s);
        foreach (stored_keys[i])
            if (stored_keys[i] == s)
                return 1'b1;
        return 1'b0;
    endfunction

    // offer one update word; called and returns at a falling edge
    task automatic put_update(input stamp_t s, input price_t p);
        int gap;
        gap = idle_draw(words_sent);
        if (gap > 0)
        begin
            upd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        upd.valid    <= 1'b1;
        upd.stamp_in <= s;
        upd.price_in <= p;
        @(posedge clk);
        while (!upd.ready)
            @(posedge clk);
        @(negedge clk);
        // a new stamp takes a slot while any is free, otherwise it is dropped
        if (!is_stored(s) && stored_keys.size() < TABLE_DEPTH)
            stored_keys.push_back(s);
        words_sent++;
    endtask

    // result sink: random stalls, plus one long hold-off that backs up the table
    initial
    begin : result_sink
        int gap;
        res.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            gap = idle_draw(words_taken);
            if (gap > 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
            @(negedge clk);
            words_taken++;
            if (words_taken == HOLD_OFF_AT)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
        end
    end

    // watchdog on cycles where no word moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((upd.valid && upd.ready) || (res.valid && res.ready))
                idle_count <= 0;
            else if (idle_count >= WATCHDOG_CYCLES)
            begin
                $display("FAIL keyed_price_table_max_min");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    initial
    begin : stimulus
        stamp_t s;
        int     pct;
        rst_n        = 1'b0;
        upd.valid    = 1'b0;
        upd.stamp_in = '0;
        upd.price_in = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, unsigned stamp order, corrections
        put_update('0, '0);                            // first entry, all zero
        put_update('1, '1);                            // top stamp, top price
        put_update(32'h8000_0000, 30'h0000_0001);      // msb set, below top stamp
        put_update(32'h7FFF_FFFF, 30'h2AAA_AAAA);      // just under msb
        put_update('1, '0);                            // correction of the latest stamp
        put_update('0, '1);                            // correction of the oldest stamp
        put_update(32'h0000_0001, 30'h1555_5555);
        put_update(32'h8000_0000, 30'h1555_5555);      // correction, price tie
        put_update(32'hFFFF_FFFE, 30'h0000_0001);
        put_update('0, '1);                            // correction with unchanged price
        put_update('1, '1);                            // latest back to top price
        put_update(32'h5555_5555, 30'h3FFF_FFFE);
        put_update(32'hAAAA_AAAA, 30'h0000_0000);
        put_update(32'hAAAA_AAAA, 30'h3FFF_FFFF);      // min moves off this slot

        // random: corrections of stored stamps mixed with new stamps; once the
        // table is full, new stamps come back dropped
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pct = (stored_keys.size() < TABLE_DEPTH) ? 50 : 60;
            if (stored_keys.size() > 0 && $urandom_range(99, 0) < pct)
                s = stored_keys[$urandom_range(stored_keys.size() - 1, 0)];
            else
                s = pick_stamp();
            put_update(s, pick_price());
        end
        upd.valid <= 1'b0;

        // drain, then keep waiting for any stray result word
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("PASS keyed_price_table_max_min");
        else
            $display("FAIL keyed_price_table_max_min");
        $finish;
    end

endmodule
